// File: rtl/crp_pkg.sv
// Content-Range parser package: widths, character codes and the prefix table.
// Used by the parser top level, its digit accumulator and the port checker.
package crp_pkg;

    localparam int BYTE_W    = 8;
    localparam int DIGIT_W   = 4;
    localparam int OUT_W     = 63;
    localparam int CNT_W     = 3;
    // m_tdata: range_start, range_end, total_length, padded to whole bytes
    localparam int M_DATA_W  = ((3 * OUT_W + 7) / 8) * 8;
    localparam int M_USER_W  = 2;

    localparam int START_LSB = 0;
    localparam int END_LSB   = OUT_W;
    localparam int LEN_LSB   = 2 * OUT_W;

    localparam int USER_VALID   = 0;
    localparam int USER_UNKNOWN = 1;

    localparam logic [CNT_W-1:0] PREFIX_LEN = 3'd6;
    localparam logic [CNT_W-1:0] MIN_LEN    = 3'd7;

    localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_STAR  = 8'h2A;
    localparam logic [BYTE_W-1:0] CHAR_DASH  = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

    // "bytes " by position
    function automatic logic [BYTE_W-1:0] prefix_char(input logic [CNT_W-1:0] idx);
        logic [BYTE_W-1:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h62;
            3'd1:    ch = 8'h79;
            3'd2:    ch = 8'h74;
            3'd3:    ch = 8'h65;
            3'd4:    ch = 8'h73;
            3'd5:    ch = CHAR_SPACE;
            default: ch = CHAR_NUL;
        endcase
        return ch;
    endfunction

endpackage

// File: rtl/crp_digit_acc.sv
// Decimal digit accumulator: acc * 10 + digit with overflow check against 2^VALUE_BITS-1.
// Depends on crp_pkg.
module crp_digit_acc #(
    parameter int VALUE_BITS = 63
) (
    input  logic [VALUE_BITS-1:0]      acc_in,
    input  logic [crp_pkg::DIGIT_W-1:0] digit,
    output logic [VALUE_BITS-1:0]      acc_out,
    output logic                       overflow
);
    import crp_pkg::*;

    localparam logic [63:0] MAX_FULL  = (64'd1 << VALUE_BITS) - 64'd1;
    localparam logic [63:0] CUT_FULL  = MAX_FULL / 64'd10;
    localparam logic [63:0] LIM_FULL  = MAX_FULL % 64'd10;
    localparam logic [VALUE_BITS-1:0] CUTOFF = CUT_FULL[VALUE_BITS-1:0];
    localparam logic [DIGIT_W-1:0]    CUTLIM = LIM_FULL[DIGIT_W-1:0];

    // times ten as two shifts and an add
    assign acc_out  = (acc_in << 3) + (acc_in << 1) + VALUE_BITS'(digit);
    assign overflow = (acc_in > CUTOFF) || ((acc_in == CUTOFF) && (digit > CUTLIM));

endmodule

// File: rtl/content_range_parser_unit.sv
// Content-Range header value parser, one byte per word: m_tvalid rises once the word
// carrying tlast has passed the input register and then the result register.
// Throughput one byte per cycle; only the last byte can wait on the result side. The
// state loop through the shared digit accumulator sets the rate.
// Reset: aresetn is synchronous, active low; clears the parse state and both valids.
module content_range_parser_unit #(
    parameter int VALUE_BITS = 63
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [crp_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] header_byte
    input  logic                         s_tlast,   // last_byte
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [crp_pkg::M_DATA_W-1:0] m_tdata,   // [62:0] range_start, [125:63] range_end,
                                                    // [188:126] total_length, rest zero
    output logic [crp_pkg::M_USER_W-1:0] m_tuser    // [0] valid_res, [1] length_unknown
);
    import crp_pkg::*;

    localparam logic [63:0] MAX_FULL = (64'd1 << VALUE_BITS) - 64'd1;
    localparam logic [VALUE_BITS-1:0] MAXV = MAX_FULL[VALUE_BITS-1:0];

    typedef enum logic [3:0] {
        PH_PREFIX, PH_SP_START, PH_START, PH_AFTER_START, PH_SP_END, PH_END,
        PH_AFTER_END, PH_SP_LEN, PH_LEN, PH_TRAIL, PH_DONE
    } phase_t;

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    // parse state
    phase_t                phase_reg, phase_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] start_reg, start_next;
    logic [VALUE_BITS-1:0] end_reg, end_next;
    logic [VALUE_BITS-1:0] len_reg, len_next;
    logic                  unk_reg, unk_next;
    logic                  err_reg, err_next;
    logic                  ended_reg, ended_next;

    // result register
    logic              m_valid_reg;
    logic              ok_reg;
    logic              unk_out_reg;
    logic [OUT_W-1:0]  start_out_reg, end_out_reg, len_out_reg;

    logic                  out_free, advance;
    logic                  is_digit, add_dig, ovf, ok;
    logic [DIGIT_W-1:0]    dig;
    logic [VALUE_BITS-1:0] acc_sel, acc_add, end_excl;

    assign out_free = !m_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;

    assign is_digit = (in_byte_reg >= CHAR_ZERO) && (in_byte_reg <= CHAR_NINE);
    assign dig      = DIGIT_W'(in_byte_reg - CHAR_ZERO);

    always_comb begin
        unique case (phase_reg)
            PH_SP_START, PH_START: acc_sel = start_reg;
            PH_SP_END, PH_END:     acc_sel = end_reg;
            default:               acc_sel = len_reg;
        endcase
    end

    crp_digit_acc #(
        .VALUE_BITS (VALUE_BITS)
    ) u_digit (
        .acc_in   (acc_sel),
        .digit    (dig),
        .acc_out  (acc_add),
        .overflow (ovf)
    );

    always_comb begin
        phase_next = phase_reg;
        start_next = start_reg;
        end_next   = end_reg;
        len_next   = len_reg;
        unk_next   = unk_reg;
        err_next   = err_reg;
        ended_next = ended_reg;
        add_dig    = 1'b0;
        cnt_next   = (cnt_reg == MIN_LEN) ? MIN_LEN : cnt_reg + 3'd1;

        if (!err_reg && !ended_reg) begin
            if (in_byte_reg == CHAR_NUL) begin
                ended_next = 1'b1;
                if (phase_reg == PH_LEN || phase_reg == PH_TRAIL) begin
                    phase_next = PH_DONE;
                end else begin
                    err_next = 1'b1;
                end
            end else begin
                unique case (phase_reg)
                    PH_PREFIX: begin
                        if (cnt_reg >= PREFIX_LEN || in_byte_reg != prefix_char(cnt_reg)) begin
                            err_next = 1'b1;
                        end else if (cnt_reg == PREFIX_LEN - 3'd1) begin
                            phase_next = PH_SP_START;
                        end
                    end
                    PH_SP_START: begin
                        if (is_digit) begin
                            add_dig    = 1'b1;
                            phase_next = PH_START;
                        end else if (in_byte_reg != CHAR_SPACE) begin
                            err_next = 1'b1;
                        end
                    end
                    PH_START: begin
                        if (is_digit)                       add_dig    = 1'b1;
                        else if (in_byte_reg == CHAR_SPACE) phase_next = PH_AFTER_START;
                        else if (in_byte_reg == CHAR_DASH)  phase_next = PH_SP_END;
                        else                                err_next   = 1'b1;
                    end
                    PH_AFTER_START: begin
                        if (in_byte_reg == CHAR_DASH)       phase_next = PH_SP_END;
                        else if (in_byte_reg != CHAR_SPACE) err_next   = 1'b1;
                    end
                    PH_SP_END: begin
                        if (is_digit) begin
                            add_dig    = 1'b1;
                            phase_next = PH_END;
                        end else if (in_byte_reg != CHAR_SPACE) begin
                            err_next = 1'b1;
                        end
                    end
                    PH_END: begin
                        if (is_digit)                       add_dig    = 1'b1;
                        else if (in_byte_reg == CHAR_SPACE) phase_next = PH_AFTER_END;
                        else if (in_byte_reg == CHAR_SLASH) phase_next = PH_SP_LEN;
                        else                                err_next   = 1'b1;
                    end
                    PH_AFTER_END: begin
                        if (in_byte_reg == CHAR_SLASH)      phase_next = PH_SP_LEN;
                        else if (in_byte_reg != CHAR_SPACE) err_next   = 1'b1;
                    end
                    PH_SP_LEN: begin
                        if (in_byte_reg == CHAR_STAR) begin
                            unk_next   = 1'b1;
                            phase_next = PH_TRAIL;
                        end else if (is_digit) begin
                            add_dig    = 1'b1;
                            phase_next = PH_LEN;
                        end else if (in_byte_reg != CHAR_SPACE) begin
                            err_next = 1'b1;
                        end
                    end
                    PH_LEN: begin
                        if (is_digit)                       add_dig    = 1'b1;
                        else if (in_byte_reg == CHAR_SPACE) phase_next = PH_TRAIL;
                        else                                err_next   = 1'b1;
                    end
                    PH_TRAIL: begin
                        if (in_byte_reg != CHAR_SPACE) err_next = 1'b1;
                    end
                    default: err_next = 1'b1;
                endcase
            end
        end

        if (add_dig) begin
            if (ovf) begin
                err_next = 1'b1;
            end else begin
                unique case (phase_reg)
                    PH_SP_START, PH_START: start_next = acc_add;
                    PH_SP_END, PH_END:     end_next   = acc_add;
                    default:               len_next   = acc_add;
                endcase
            end
        end
    end

    // End of value acts as a zero byte. The end offset cannot change on a byte
    // that leaves a good value, so the increment works from the register.
    assign ok = !err_next && (cnt_next == MIN_LEN) &&
                (ended_next ? (phase_next == PH_DONE)
                            : (phase_next == PH_LEN || phase_next == PH_TRAIL));
    assign end_excl = (end_reg >= MAXV) ? MAXV : end_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (advance && in_last_reg)) begin
            phase_reg <= PH_PREFIX;
            cnt_reg   <= '0;
            start_reg <= '0;
            end_reg   <= '0;
            len_reg   <= '0;
            unk_reg   <= 1'b0;
            err_reg   <= 1'b0;
            ended_reg <= 1'b0;
        end else if (advance) begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            start_reg <= start_next;
            end_reg   <= end_next;
            len_reg   <= len_next;
            unk_reg   <= unk_next;
            err_reg   <= err_next;
            ended_reg <= ended_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (advance && in_last_reg) begin
            ok_reg        <= ok;
            unk_out_reg   <= ok && unk_next;
            start_out_reg <= ok ? OUT_W'(start_reg) : '0;
            end_out_reg   <= ok ? OUT_W'(end_excl) : '0;
            len_out_reg   <= (ok && !unk_next) ? OUT_W'(len_next) : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    always_comb begin
        m_tdata                            = '0;
        m_tdata[START_LSB +: OUT_W]        = start_out_reg;
        m_tdata[END_LSB +: OUT_W]          = end_out_reg;
        m_tdata[LEN_LSB +: OUT_W]          = len_out_reg;
        m_tuser                            = '0;
        m_tuser[USER_VALID]                = ok_reg;
        m_tuser[USER_UNKNOWN]              = unk_out_reg;
    end

endmodule

// File: rtl/crp_checker.sv
// Port-level checker for content_range_parser_unit, attached by bind.
// Depends on crp_pkg.
module crp_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [crp_pkg::M_DATA_W-1:0] m_tdata,
    input logic [crp_pkg::M_USER_W-1:0] m_tuser
);
    import crp_pkg::*;

    // a failed parse carries an all-zero result
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[USER_VALID]) |-> (m_tdata == '0 && !m_tuser[USER_UNKNOWN]))
        else $error("invalid result carries nonzero fields");

    // unknown length reports zero total length
    a_unknown_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[USER_UNKNOWN]) |-> (m_tdata[LEN_LSB +: OUT_W] == '0))
        else $error("unknown length with nonzero total");

    // exclusive end is at least one on a good parse
    a_end_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[USER_VALID]) |-> (m_tdata[END_LSB +: OUT_W] != '0))
        else $error("valid result with zero exclusive end");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind content_range_parser_unit crp_checker u_crp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
